// File: rtl/wafmt_pkg.sv
// ----------------------------------------------------------------------------
// wafmt_pkg: shared definitions of the word to ASCII radix formatter
// Widths, format codes, character constants, the byte swap function and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package wafmt_pkg;

    localparam int C_IN_BITS     = 32;
    localparam int C_WORD_BITS   = 32;
    localparam int C_EXT_BITS    = (C_WORD_BITS > C_IN_BITS) ? C_WORD_BITS : C_IN_BITS;
    localparam int C_NUM_BYTES   = C_WORD_BITS / 8;
    localparam int C_DEC_DIGITS  = (C_WORD_BITS * 30103) / 100000 + 1;
    localparam int C_BCD_BITS    = 4 * C_DEC_DIGITS;
    localparam int C_PAD_BITS    = 12 * ((C_WORD_BITS + 11) / 12);
    localparam int C_HEX_DIGITS  = C_PAD_BITS / 4;
    localparam int C_OCT_DIGITS  = C_PAD_BITS / 3;
    localparam int C_BIN_DIGITS  = C_PAD_BITS;
    localparam int C_CNT_BITS    = $clog2(C_PAD_BITS + 1);

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEX  = 3'd2;
    localparam logic [2:0] OP_OCT  = 3'd3;
    localparam logic [2:0] OP_BIN  = 3'd4;

    localparam logic [1:0] CH_ZERO  = 2'd0;
    localparam logic [1:0] CH_RADIX = 2'd1;
    localparam logic [1:0] CH_MINUS = 2'd2;
    localparam logic [1:0] CH_DIGIT = 2'd3;

    localparam logic [6:0] C_ASCII_ZERO  = 7'h30;
    localparam logic [6:0] C_ASCII_MINUS = 7'h2d;
    localparam logic [6:0] C_ASCII_X     = 7'h78;
    localparam logic [6:0] C_ASCII_O     = 7'h6f;
    localparam logic [6:0] C_ASCII_B     = 7'h62;
    localparam logic [6:0] C_ASCII_ALPHA = 7'h57;

    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       emit;
        logic       last;
        logic       shift;
        logic [1:0] ch_sel;
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic digit_zero;
        logic neg;
    } t_dp_sts;

    function automatic logic [C_WORD_BITS-1:0] f_swap(input logic [C_WORD_BITS-1:0] v);
        logic [C_WORD_BITS-1:0] r;
        r = v;
        for (int k = 0; k < C_NUM_BYTES; k++) begin
            r[(C_NUM_BYTES-1-k)*8 +: 8] = v[k*8 +: 8];
        end
        return r;
    endfunction

endpackage

// File: rtl/word_to_ascii_radix_formatter.sv
// ----------------------------------------------------------------------------
// word_to_ascii_radix_formatter: word to ASCII text in five radix formats
//
//   Channel   Direction  Signals                              Contents
//   s         in         i_s_tvalid/o_s_tready/i_s_tdata/user one word + format
//   m         out        o_m_tvalid/i_m_tready/o_m_tdata/last one character
//
// Decimal accepts the word, runs shift-and-add-3 conversion over all of
// its bits, then emits a minus sign if negative and the digits.
// Hex, octal and binary accept the word, emit a two-character prefix, then
// the digits of the padded word. All formats skip leading zero digits.
// Reset is synchronous and clears the controller and the output beat valid.
// A stalled output beat holds the controller's emitting states; the next
// word is taken once the last character sits in the output register.
// ----------------------------------------------------------------------------
module word_to_ascii_radix_formatter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wafmt_pkg::C_IN_BITS-1:0] i_s_tdata,   // [31:0] value_word
    input  logic [3:0]                      i_s_tuser,   // [2:0] op, [3] swap_bytes
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,   // [6:0] char_code, [7] zero
    output logic                            o_m_tlast    // last_char
);
    import wafmt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [6:0] char_code;

    wafmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser[2:0]),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wafmt_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value_word (i_s_tdata),
        .i_swap_bytes (i_s_tuser[3]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_char_code  (char_code),
        .o_last_char  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, char_code};

endmodule

// File: rtl/wafmt_dpath.sv
// ----------------------------------------------------------------------------
// wafmt_dpath: datapath of the word to ASCII radix formatter
// Holds the word, the shift-and-add-3 BCD converter, the digit shifter and
// the output register of the result stream.
// ----------------------------------------------------------------------------
module wafmt_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [wafmt_pkg::C_IN_BITS-1:0]      i_value_word,
    input  logic                                 i_swap_bytes,
    input  wafmt_pkg::t_dp_cmd                   i_cmd,
    output wafmt_pkg::t_dp_sts                   o_sts,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [6:0]                           o_char_code,
    output logic                                 o_last_char
);
    import wafmt_pkg::*;

    logic [C_PAD_BITS-1:0]  r_val;
    logic [C_PAD_BITS-1:0]  n_val;
    logic [C_BCD_BITS-1:0]  r_bcd;
    logic [C_BCD_BITS-1:0]  n_bcd;
    logic                   r_neg;
    logic                   r_out_valid;
    logic [6:0]             r_out_char;
    logic                   r_out_last;

    logic [C_EXT_BITS-1:0]  in_ext;
    logic [C_WORD_BITS-1:0] in_word;
    logic [C_WORD_BITS-1:0] swapped;
    logic [C_WORD_BITS-1:0] mag;
    logic                   load_neg;
    logic [C_BCD_BITS-1:0]  bcd_adj;
    logic [3:0]             digit;
    logic [6:0]             digit_char;
    logic [6:0]             radix_char;
    logic [6:0]             sel_char;

    always_comb begin
        in_ext   = C_EXT_BITS'(i_value_word);
        in_word  = in_ext[C_WORD_BITS-1:0];
        swapped  = i_swap_bytes ? f_swap(in_word) : in_word;
        load_neg = (i_cmd.op == OP_SDEC) && swapped[C_WORD_BITS-1];
        mag      = load_neg ? (~swapped + 1'b1) : swapped;
    end

    always_comb begin
        for (int d = 0; d < C_DEC_DIGITS; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? (r_bcd[d*4 +: 4] + 4'd3)
                                                          : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_HEX:  digit = r_val[C_PAD_BITS-1 -: 4];
            OP_OCT:  digit = {1'b0, r_val[C_PAD_BITS-1 -: 3]};
            OP_BIN:  digit = {3'b000, r_val[C_PAD_BITS-1]};
            default: digit = r_bcd[C_BCD_BITS-1 -: 4];
        endcase
        digit_char = (digit < 4'd10) ? (C_ASCII_ZERO + {3'b000, digit})
                                     : (C_ASCII_ALPHA + {3'b000, digit});
        unique case (i_cmd.op)
            OP_HEX:  radix_char = C_ASCII_X;
            OP_OCT:  radix_char = C_ASCII_O;
            default: radix_char = C_ASCII_B;
        endcase
        unique case (i_cmd.ch_sel)
            CH_ZERO:  sel_char = C_ASCII_ZERO;
            CH_RADIX: sel_char = radix_char;
            CH_MINUS: sel_char = C_ASCII_MINUS;
            default:  sel_char = digit_char;
        endcase
    end

    always_comb begin
        n_val = r_val;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_val = C_PAD_BITS'(mag);
            n_bcd = '0;
        end else if (i_cmd.dabble) begin
            n_bcd = {bcd_adj[C_BCD_BITS-2:0], r_val[C_WORD_BITS-1]};
            n_val = r_val << 1;
        end else if (i_cmd.shift) begin
            unique case (i_cmd.op)
                OP_HEX:  n_val = r_val << 4;
                OP_OCT:  n_val = r_val << 3;
                OP_BIN:  n_val = r_val << 1;
                default: n_bcd = r_bcd << 4;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_bcd <= n_bcd;
        if (i_cmd.load) begin
            r_neg <= load_neg;
        end
        if (i_cmd.emit) begin
            r_out_char <= sel_char;
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_sts.digit_zero = (digit == 4'd0);
    assign o_sts.neg        = r_neg;
    assign o_m_tvalid       = r_out_valid;
    assign o_char_code      = r_out_char;
    assign o_last_char      = r_out_last;

endmodule

// File: rtl/wafmt_ctrl.sv
// ----------------------------------------------------------------------------
// wafmt_ctrl: controller of the word to ASCII radix formatter
// Sequences prefix, conversion, sign and digit steps and suppresses leading
// zeros.
// ----------------------------------------------------------------------------
module wafmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2:0]          i_op,
    input  wafmt_pkg::t_dp_sts  i_sts,
    output wafmt_pkg::t_dp_cmd  o_cmd
);
    import wafmt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE0   = 3'd1;
    localparam logic [2:0] S_PRE1   = 3'd2;
    localparam logic [2:0] S_CONV   = 3'd3;
    localparam logic [2:0] S_SIGN   = 3'd4;
    localparam logic [2:0] S_DIGITS = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [2:0]            r_op;
    logic [2:0]            n_op;
    logic [C_CNT_BITS-1:0] r_cnt;
    logic [C_CNT_BITS-1:0] n_cnt;
    logic                  r_started;
    logic                  n_started;
    logic                  cnt_last;

    assign cnt_last   = (r_cnt == C_CNT_BITS'(1));
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_started = r_started;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        o_cmd.ch_sel = CH_DIGIT;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op = i_op;
                if (i_s_tvalid) begin
                    n_op      = i_op;
                    n_started = 1'b0;
                    if (i_op == OP_SDEC || i_op == OP_UDEC) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = C_CNT_BITS'(C_WORD_BITS);
                        n_state    = S_CONV;
                    end else if (i_op == OP_HEX || i_op == OP_OCT || i_op == OP_BIN) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_PRE0;
                    end
                end
            end
            S_PRE0: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.ch_sel = CH_ZERO;
                    n_state      = S_PRE1;
                end
            end
            S_PRE1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.ch_sel = CH_RADIX;
                    unique case (r_op)
                        OP_HEX:  n_cnt = C_CNT_BITS'(C_HEX_DIGITS);
                        OP_OCT:  n_cnt = C_CNT_BITS'(C_OCT_DIGITS);
                        default: n_cnt = C_CNT_BITS'(C_BIN_DIGITS);
                    endcase
                    n_state = S_DIGITS;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (cnt_last) begin
                    n_cnt   = C_CNT_BITS'(C_DEC_DIGITS);
                    n_state = i_sts.neg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.ch_sel = CH_MINUS;
                    n_state      = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (i_sts.digit_zero && !r_started && !cnt_last) begin
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.last  = cnt_last;
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                    n_started   = 1'b1;
                    if (cnt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_SDEC;
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_started <= n_started;
        end
    end

endmodule
